[rtl/core/alp_pkg.sv]
// alp_pkg: types and constants for the address lease pool core.
// No dependencies; used by address_lease_pool_core.
`default_nettype none
package alp_pkg;

	localparam logic [31:0] POOL_FIRST_RST = 32'hC0A8_0164;
	localparam logic [31:0] POOL_LAST_RST = 32'hC0A8_01C8;
	localparam logic [30:0] LEASE_SEC_RST = 31'd86400;

	typedef enum logic [2:0] {
		ACT_DISCOVER = 3'd0,
		ACT_REQUEST = 3'd1,
		ACT_RELEASE = 3'd2,
		ACT_TICK = 3'd3,
		ACT_CLEANUP = 3'd4
	} action_t;

	typedef enum logic [1:0] {
		ST_OK = 2'd0,
		ST_EXHAUSTED = 2'd1,
		ST_FULL = 2'd2,
		ST_NOMATCH = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		CFG_POOL_FIRST = 2'd0,
		CFG_POOL_LAST = 2'd1,
		CFG_LEASE_SEC = 2'd2
	} cfg_idx_t;

	typedef enum logic [2:0] {
		S_IDLE,
		S_RD,
		S_CHK,
		S_DONE
	} state_t;

	typedef struct packed {
		logic [2:0] action;
		logic [31:0] address;
	} in_word_t;

	typedef struct packed {
		logic [1:0] status;
		logic [31:0] offered_address;
		logic [7:0] expired_count;
	} out_word_t;

endpackage
`default_nettype wire

[rtl/core/alp_ram.sv]
// alp_ram: generic single-port-write, single-read RAM with registered read.
// No dependencies.
`default_nettype none
module alp_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

[rtl/core/address_lease_pool_core.sv]
// address_lease_pool_core: lease table with discover/request/release/tick/cleanup.
// Depends on alp_pkg and alp_ram.
//
// channel   dir   handshake          payload
// in        in    in_valid/in_ready  alp_pkg::in_word_t
// out       out   out_valid/out_ready alp_pkg::out_word_t
// cfg       in    cfg_we             cfg_index, cfg_data
//
// Request, tick: S_IDLE, S_RD, then S_DONE. Release, cleanup: S_RD and S_CHK per table entry.
// Discover: S_RD and S_CHK per entry for each candidate address tried, at most
// (TABLE_ENTRIES+1) candidates; the single table read port sets this pace.
// Reset clears entry count, valid bits and clock; the table RAM is not cleared.
// in_ready is low while an item is at work or its result waits on out_ready.
`default_nettype none
module address_lease_pool_core #(
	parameter int TABLE_ENTRIES = 128
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic in_valid,
	output logic in_ready,
	input wire alp_pkg::in_word_t in_data,
	output logic out_valid,
	input wire logic out_ready,
	output alp_pkg::out_word_t out_data,
	input wire logic cfg_we,
	input wire logic [1:0] cfg_index,
	input wire logic [31:0] cfg_data
);
	localparam int AW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam int CW = $clog2(TABLE_ENTRIES + 1);

	logic [31:0] pool_first_q, pool_last_q;
	logic [30:0] lease_sec_q;
	logic [31:0] now_q;
	logic [CW-1:0] count_q;
	logic [TABLE_ENTRIES-1:0] active_q;

	alp_pkg::state_t state_q, state_d;
	logic [2:0] act_q;
	logic [31:0] addr_q;
	logic [31:0] cand_q;
	logic [CW-1:0] idx_q;
	logic [7:0] exp_q;
	logic [AW-1:0] ridx;
	logic [31:0] r_addr, r_start, r_len;
	logic we;
	logic [AW-1:0] widx;
	logic [31:0] elapsed;
	logic scan_end, hit;

	assign widx = count_q[AW-1:0];
	assign we = (state_q == alp_pkg::S_IDLE) && in_valid && in_ready
		&& (in_data.action == alp_pkg::ACT_REQUEST)
		&& (count_q < CW'(TABLE_ENTRIES));
	assign ridx = idx_q[AW-1:0];

	alp_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_addr (
		.clk(clk), .we(we), .waddr(widx), .wdata(in_data.address),
		.raddr(ridx), .rdata(r_addr));
	alp_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_start (
		.clk(clk), .we(we), .waddr(widx), .wdata(now_q),
		.raddr(ridx), .rdata(r_start));
	alp_ram #(.WIDTH(32), .DEPTH(TABLE_ENTRIES)) u_len (
		.clk(clk), .we(we), .waddr(widx), .wdata({1'b0, lease_sec_q}),
		.raddr(ridx), .rdata(r_len));

	// shared compare unit: one entry per check cycle
	assign elapsed = now_q - r_start;
	assign scan_end = (idx_q >= count_q);
	always_comb begin
		hit = 1'b0;
		case (act_q)
			alp_pkg::ACT_DISCOVER: hit = active_q[ridx] && (r_addr == cand_q);
			alp_pkg::ACT_RELEASE: hit = (r_addr == addr_q);
			alp_pkg::ACT_CLEANUP: hit = active_q[ridx] && (elapsed > r_len);
			default: hit = 1'b0;
		endcase
	end

	assign in_ready = (state_q == alp_pkg::S_IDLE);
	assign out_valid = (state_q == alp_pkg::S_DONE);

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			alp_pkg::S_IDLE: if (in_valid) state_d = alp_pkg::S_RD;
			alp_pkg::S_RD: begin
				if (act_q == alp_pkg::ACT_REQUEST || act_q == alp_pkg::ACT_TICK
						|| scan_end || (act_q != alp_pkg::ACT_DISCOVER
						&& act_q != alp_pkg::ACT_RELEASE
						&& act_q != alp_pkg::ACT_CLEANUP)) begin
					state_d = alp_pkg::S_DONE;
				end else begin
					state_d = alp_pkg::S_CHK;
				end
			end
			alp_pkg::S_CHK: state_d = alp_pkg::S_RD;
			alp_pkg::S_DONE: if (out_ready) state_d = alp_pkg::S_IDLE;
			default: state_d = alp_pkg::S_IDLE;
		endcase
	end

	// sequencer datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= alp_pkg::S_IDLE;
			pool_first_q <= alp_pkg::POOL_FIRST_RST;
			pool_last_q <= alp_pkg::POOL_LAST_RST;
			lease_sec_q <= alp_pkg::LEASE_SEC_RST;
			now_q <= '0;
			count_q <= '0;
			active_q <= '0;
			out_data <= '0;
			act_q <= '0;
			addr_q <= '0;
			cand_q <= '0;
			idx_q <= '0;
			exp_q <= '0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				case (cfg_index)
					alp_pkg::CFG_POOL_FIRST: pool_first_q <= cfg_data;
					alp_pkg::CFG_POOL_LAST: pool_last_q <= cfg_data;
					alp_pkg::CFG_LEASE_SEC: lease_sec_q <= cfg_data[30:0];
					default: ;
				endcase
			end
			case (state_q)
				alp_pkg::S_IDLE: if (in_valid) begin
					addr_q <= in_data.address;
					cand_q <= pool_first_q;
					idx_q <= '0;
					exp_q <= '0;
					out_data.offered_address <= '0;
					out_data.expired_count <= '0;
					// an empty pool finishes discover at once
					if (in_data.action == alp_pkg::ACT_DISCOVER
							&& pool_first_q > pool_last_q) begin
						act_q <= alp_pkg::ACT_TICK;
					end else begin
						act_q <= in_data.action;
					end
					if (in_data.action == alp_pkg::ACT_REQUEST
							&& count_q >= CW'(TABLE_ENTRIES)) begin
						out_data.status <= alp_pkg::ST_FULL;
					end else if (in_data.action == alp_pkg::ACT_RELEASE) begin
						out_data.status <= alp_pkg::ST_NOMATCH;
					end else if (in_data.action == alp_pkg::ACT_DISCOVER
							&& pool_first_q > pool_last_q) begin
						out_data.status <= alp_pkg::ST_EXHAUSTED;
					end else begin
						out_data.status <= alp_pkg::ST_OK;
					end
					if (in_data.action == alp_pkg::ACT_REQUEST
							&& count_q < CW'(TABLE_ENTRIES)) begin
						active_q[widx] <= 1'b1;
						count_q <= count_q + 1'b1;
					end
					if (in_data.action == alp_pkg::ACT_TICK) now_q <= now_q + 1'b1;
				end
				alp_pkg::S_RD: begin
					if (scan_end && act_q == alp_pkg::ACT_DISCOVER)
						out_data.offered_address <= cand_q;
					if (act_q == alp_pkg::ACT_CLEANUP) out_data.expired_count <= exp_q;
				end
				alp_pkg::S_CHK: begin
					if (!hit) begin
						idx_q <= idx_q + 1'b1;
					end else begin
						case (act_q)
							alp_pkg::ACT_DISCOVER: begin
								if (cand_q == pool_last_q) begin
									out_data.status <= alp_pkg::ST_EXHAUSTED;
									idx_q <= count_q;
									act_q <= alp_pkg::ACT_TICK;
								end else begin
									idx_q <= '0;
									cand_q <= cand_q + 1'b1;
								end
							end
							alp_pkg::ACT_RELEASE: begin
								active_q[ridx] <= 1'b0;
								out_data.status <= alp_pkg::ST_OK;
								idx_q <= count_q;
							end
							alp_pkg::ACT_CLEANUP: begin
								active_q[ridx] <= 1'b0;
								idx_q <= idx_q + 1'b1;
								if (exp_q != 8'hFF) exp_q <= exp_q + 1'b1;
							end
							default: idx_q <= idx_q + 1'b1;
						endcase
					end
				end
				default: ;
			endcase
		end
	end

	// checks
	ap_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready |-> !out_valid) else $error("ready while result pending");
	ap_count_max: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(TABLE_ENTRIES)) else $error("entry count overflow");
	ap_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_data))
		else $error("result changed while stalled");
	ap_cnt_req: assert property (@(posedge clk) disable iff (!arst_n)
		!in_ready |=> $stable(count_q)) else $error("count moved mid-item");
endmodule
`default_nettype wire
